// ===== src/tkd_pkg.sv =====
// tkd_pkg: shared constants and types of the top-k select unit with id dedup
// used by tkd_cell, tkd_chain and top_k_select_with_dedup_unit
// no dependencies
package tkd_pkg;

    // default sizes, used as the defaults of the top level parameters
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF     = 24;
    localparam int SCORE_BITS_DEF  = 32;

    // capacity register
    localparam int             CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // chain operations
    typedef logic [2:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 3'd0;
    localparam cell_op_t OP_INSERT = 3'd1;  // shift up above the insert slot
    localparam cell_op_t OP_EVICT  = 3'd2;  // shift down below the insert slot
    localparam cell_op_t OP_DROP   = 3'd3;  // shift whole chain down by one
    localparam cell_op_t OP_ROTATE = 3'd4;  // rotate held entries down by one

    typedef struct packed {
        logic     load;  // capture compare flags against the candidate
        cell_op_t op;
    } cell_ctrl_t;

endpackage

// ===== src/tkd_cell.sv =====
// tkd_cell: one slot of the sorted chain, holds an id and a score
// and its compare flags against the current candidate
// depends on tkd_pkg
module tkd_cell #(
    parameter int ID_BITS    = tkd_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = tkd_pkg::SCORE_BITS_DEF
) (
    input  logic                   clk,
    input  tkd_pkg::cell_ctrl_t    ctrl,
    input  logic                   valid,
    input  logic                   is_top,
    input  logic [ID_BITS-1:0]     in_id,
    input  logic [SCORE_BITS-1:0]  in_score,
    input  logic [ID_BITS-1:0]     lo_id,
    input  logic [SCORE_BITS-1:0]  lo_score,
    input  logic                   lo_above,
    input  logic [ID_BITS-1:0]     hi_id,
    input  logic [SCORE_BITS-1:0]  hi_score,
    input  logic                   hi_above,
    input  logic [ID_BITS-1:0]     wrap_id,
    input  logic [SCORE_BITS-1:0]  wrap_score,
    output logic [ID_BITS-1:0]     id,
    output logic [SCORE_BITS-1:0]  score,
    output logic                   above,
    output logic                   match
);

    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [SCORE_BITS-1:0] score_reg, score_next;
    logic                  above_reg, above_next;
    logic                  match_reg, match_next;

    always_comb
    begin
        id_next    = id_reg;
        score_next = score_reg;
        case (ctrl.op)
            tkd_pkg::OP_HOLD:
            begin
                id_next    = id_reg;
                score_next = score_reg;
            end
            tkd_pkg::OP_INSERT:
            begin
                if (lo_above)
                begin
                    id_next    = lo_id;
                    score_next = lo_score;
                end
                else if (above_reg)
                begin
                    id_next    = in_id;
                    score_next = in_score;
                end
            end
            tkd_pkg::OP_EVICT:
            begin
                if (!hi_above)
                begin
                    id_next    = hi_id;
                    score_next = hi_score;
                end
                else if (!above_reg)
                begin
                    id_next    = in_id;
                    score_next = in_score;
                end
            end
            tkd_pkg::OP_DROP:
            begin
                id_next    = hi_id;
                score_next = hi_score;
            end
            tkd_pkg::OP_ROTATE:
            begin
                if (is_top)
                begin
                    id_next    = wrap_id;
                    score_next = wrap_score;
                end
                else if (valid)
                begin
                    id_next    = hi_id;
                    score_next = hi_score;
                end
            end
            default:
            begin
                id_next    = id_reg;
                score_next = score_reg;
            end
        endcase
    end

    // empty slots count as above any candidate so inserts land below them
    always_comb
    begin
        above_next = above_reg;
        match_next = match_reg;
        if (ctrl.load)
        begin
            above_next = !valid || (score_reg > in_score);
            match_next = valid && (id_reg == in_id);
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        score_reg <= score_next;
        above_reg <= above_next;
        match_reg <= match_next;
    end

    assign id    = id_reg;
    assign score = score_reg;
    assign above = above_reg;
    assign match = match_reg;

endmodule

// ===== src/tkd_chain.sv =====
// tkd_chain: row of tkd_cell slots kept in ascending score order, lowest at slot 0
// wires neighbors together and reduces the duplicate-id flags
// depends on tkd_pkg and tkd_cell
module tkd_chain #(
    parameter int MAX_ENTRIES = tkd_pkg::MAX_ENTRIES_DEF,
    parameter int ID_BITS     = tkd_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS  = tkd_pkg::SCORE_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                   clk,
    input  tkd_pkg::cell_ctrl_t    ctrl,
    input  logic [CNT_W-1:0]       count,
    input  logic [ID_BITS-1:0]     in_id,
    input  logic [SCORE_BITS-1:0]  in_score,
    output logic                   any_match,
    output logic [ID_BITS-1:0]     low_id,
    output logic [SCORE_BITS-1:0]  low_score
);

    logic [ID_BITS-1:0]    id_q    [MAX_ENTRIES];
    logic [SCORE_BITS-1:0] score_q [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] above_q;
    logic [MAX_ENTRIES-1:0] match_q;
    logic [MAX_ENTRIES-1:0] valid;

    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            localparam logic [CNT_W-1:0] SLOT = CNT_W'(i);

            logic [ID_BITS-1:0]    lo_id, hi_id;
            logic [SCORE_BITS-1:0] lo_score, hi_score;
            logic                  lo_above, hi_above, hi_valid;

            assign valid[i] = SLOT < count;

            if (i == 0)
            begin : g_bottom
                assign lo_id    = '0;
                assign lo_score = '0;
                assign lo_above = 1'b0;
            end
            else
            begin : g_lo
                assign lo_id    = id_q[i-1];
                assign lo_score = score_q[i-1];
                assign lo_above = above_q[i-1];
            end

            if (i == MAX_ENTRIES - 1)
            begin : g_top
                assign hi_id    = '0;
                assign hi_score = '0;
                assign hi_above = 1'b1;
                assign hi_valid = 1'b0;
            end
            else
            begin : g_hi
                assign hi_id    = id_q[i+1];
                assign hi_score = score_q[i+1];
                assign hi_above = above_q[i+1];
                assign hi_valid = SLOT + CNT_W'(1) < count;
            end

            tkd_cell #(
                .ID_BITS    (ID_BITS),
                .SCORE_BITS (SCORE_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (valid[i]),
                .is_top     (valid[i] && !hi_valid),
                .in_id      (in_id),
                .in_score   (in_score),
                .lo_id      (lo_id),
                .lo_score   (lo_score),
                .lo_above   (lo_above),
                .hi_id      (hi_id),
                .hi_score   (hi_score),
                .hi_above   (hi_above),
                .wrap_id    (id_q[0]),
                .wrap_score (score_q[0]),
                .id         (id_q[i]),
                .score      (score_q[i]),
                .above      (above_q[i]),
                .match      (match_q[i])
            );
        end
    endgenerate

    assign any_match = |match_q;
    assign low_id    = id_q[0];
    assign low_score = score_q[0];

endmodule

// ===== src/top_k_select_with_dedup_unit.sv =====
// top_k_select_with_dedup_unit: top level, command sequencer, capacity register
// and output register around the sorted cell chain
// depends on tkd_pkg and tkd_chain
//
// Keeps the best capacity candidates (record id, unsigned Q16.16 score) in a chain of
// cells sorted by ascending score, the oldest entry lowest among equal scores. An insert
// is accepted, compared in every cell, shifts the chain and then loads the output
// register, and no item is taken until that result is loaded. A readout gives one
// result per held entry (one for an empty store) as the downstream side takes them:
// the chain rotates by one slot per result and is back in place at the end. After
// capacity is lowered below the held count, and while no readout is in progress,
// the lowest entries are dropped one per cycle, and no item is taken until that is
// done. The capacity register may be written at any time the block is idle.
module top_k_select_with_dedup_unit #(
    parameter int MAX_ENTRIES = tkd_pkg::MAX_ENTRIES_DEF,
    parameter int ID_BITS     = tkd_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS  = tkd_pkg::SCORE_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    // capacity register write channel
    input  logic                                           cfg_valid,
    output logic                                           cfg_ready,
    input  logic [tkd_pkg::CAP_W-1:0]                      cfg_data,
    // command input
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // record_id, score
    input  logic [((ID_BITS+SCORE_BITS+7)/8)*8-1:0]        s_tdata,
    // command
    input  logic                                           s_tuser,
    // result output
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // accepted, full_res, lowest_score, entry_id, entry_score
    output logic [((2+2*SCORE_BITS+ID_BITS+7)/8)*8-1:0]    m_tdata,
    // entry_valid
    output logic                                           m_tuser,
    output logic                                           m_tlast
);

    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int OUT_DATA_W = ((2 + 2 * SCORE_BITS + ID_BITS + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CMP    = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    // readout is tracked by its own flag so the four codes above stay distinct
    logic [1:0]                 state_reg, state_next;
    logic                       read_reg, read_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           rd_cnt_reg, rd_cnt_next;
    logic [tkd_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic                       acc_reg, acc_next;
    logic [ID_BITS-1:0]         item_id_reg, item_id_next;
    logic [SCORE_BITS-1:0]      item_score_reg, item_score_next;
    logic [SCORE_BITS-1:0]      low_reg, low_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_acc_reg, out_acc_next;
    logic                       out_full_reg, out_full_next;
    logic [SCORE_BITS-1:0]      out_low_reg, out_low_next;
    logic [ID_BITS-1:0]         out_id_reg, out_id_next;
    logic [SCORE_BITS-1:0]      out_score_reg, out_score_next;
    logic                       out_ev_reg, out_ev_next;
    logic                       out_last_reg, out_last_next;

    tkd_pkg::cell_ctrl_t        ctrl;
    logic                       any_match;
    logic [ID_BITS-1:0]         low_id;
    logic [SCORE_BITS-1:0]      low_score;

    logic [31:0]                cap_wide;
    logic [31:0]                eff_wide;
    logic [CNT_W-1:0]           eff_cap;
    logic                       over_cap;
    logic                       full_now;
    logic [SCORE_BITS-1:0]      lowest_now;
    logic                       out_free;
    logic                       in_fire;
    logic                       acc;

    // capacity 0 acts as 1, above the chain depth acts as the depth
    assign cap_wide = 32'(cap_reg);
    always_comb
    begin
        if (cap_wide == 32'd0)
            eff_wide = 32'd1;
        else if (cap_wide > 32'(MAX_ENTRIES))
            eff_wide = 32'(MAX_ENTRIES);
        else
            eff_wide = cap_wide;
    end
    assign eff_cap = CNT_W'(eff_wide);

    assign over_cap   = count_reg > eff_cap;
    assign full_now   = count_reg >= eff_cap;
    assign lowest_now = (count_reg != '0) ? low_score : '0;
    assign out_free   = !out_valid_reg || m_tready;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !read_reg && !over_cap;
    assign in_fire   = s_tvalid && s_tready;

    assign acc = !any_match &&
                 ((count_reg < eff_cap) || ((count_reg != '0) && (item_score_reg > low_score)));

    always_comb
    begin
        state_next      = state_reg;
        read_next       = read_reg;
        count_next      = count_reg;
        rd_cnt_next     = rd_cnt_reg;
        cap_next        = cap_reg;
        acc_next        = acc_reg;
        item_id_next    = item_id_reg;
        item_score_next = item_score_reg;
        low_next        = low_reg;
        out_valid_next  = out_valid_reg;
        out_acc_next    = out_acc_reg;
        out_full_next   = out_full_reg;
        out_low_next    = out_low_reg;
        out_id_next     = out_id_reg;
        out_score_next  = out_score_reg;
        out_ev_next     = out_ev_reg;
        out_last_next   = out_last_reg;
        ctrl.load       = 1'b0;
        ctrl.op         = tkd_pkg::OP_HOLD;

        if (cfg_valid && cfg_ready)
            cap_next = cfg_data;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (read_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_acc_next   = 1'b0;
                        out_full_next  = full_now;
                        out_low_next   = low_reg;
                        if (count_reg == '0)
                        begin
                            out_id_next    = '0;
                            out_score_next = '0;
                            out_ev_next    = 1'b0;
                            out_last_next  = 1'b1;
                            read_next      = 1'b0;
                        end
                        else
                        begin
                            out_id_next    = low_id;
                            out_score_next = low_score;
                            out_ev_next    = 1'b1;
                            ctrl.op        = tkd_pkg::OP_ROTATE;
                            if (rd_cnt_reg + CNT_W'(1) == count_reg)
                            begin
                                out_last_next = 1'b1;
                                rd_cnt_next   = '0;
                                read_next     = 1'b0;
                            end
                            else
                            begin
                                out_last_next = 1'b0;
                                rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                else if (over_cap)
                begin
                    // capacity lowered: drop the lowest entry each cycle
                    ctrl.op    = tkd_pkg::OP_DROP;
                    count_next = count_reg - CNT_W'(1);
                end
                else if (in_fire)
                begin
                    item_id_next    = s_tdata[ID_BITS-1:0];
                    item_score_next = s_tdata[ID_BITS +: SCORE_BITS];
                    if (s_tuser)
                    begin
                        read_next   = 1'b1;
                        rd_cnt_next = '0;
                        low_next    = lowest_now;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                ctrl.load  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                acc_next = acc;
                if (acc)
                begin
                    if (full_now)
                        ctrl.op = tkd_pkg::OP_EVICT;
                    else
                    begin
                        ctrl.op    = tkd_pkg::OP_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_full_next  = full_now;
                    out_low_next   = lowest_now;
                    out_id_next    = '0;
                    out_score_next = '0;
                    out_ev_next    = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tkd_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS),
        .SCORE_BITS  (SCORE_BITS),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count_reg),
        .in_id     (item_id_reg),
        .in_score  (item_score_reg),
        .any_match (any_match),
        .low_id    (low_id),
        .low_score (low_score)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            read_reg      <= 1'b0;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            cap_reg       <= tkd_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            read_reg      <= read_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        item_id_reg    <= item_id_next;
        item_score_reg <= item_score_next;
        low_reg        <= low_next;
        out_acc_reg    <= out_acc_next;
        out_full_reg   <= out_full_next;
        out_low_reg    <= out_low_next;
        out_id_reg     <= out_id_next;
        out_score_reg  <= out_score_next;
        out_ev_reg     <= out_ev_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_score_reg, out_id_reg, out_low_reg,
                                   out_full_reg, out_acc_reg});
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== dv/tb_top_k_select_with_dedup_unit.sv =====
`timescale 1ns / 100ps
// tb_top_k_select_with_dedup_unit: self-checking bench for the top-k select unit,
// a directed table then random inserts and readouts, checked against a local score store
// depends on tkd_pkg and top_k_select_with_dedup_unit
module tb_top_k_select_with_dedup_unit;

    localparam int MAX_ENTRIES = tkd_pkg::MAX_ENTRIES_DEF;
    localparam int ID_BITS     = tkd_pkg::ID_BITS_DEF;
    localparam int SCORE_BITS  = tkd_pkg::SCORE_BITS_DEF;
    localparam int CAP_W       = tkd_pkg::CAP_W;
    localparam int S_W         = ((ID_BITS + SCORE_BITS + 7) / 8) * 8;
    localparam int M_W         = ((2 + 2 * SCORE_BITS + ID_BITS + 7) / 8) * 8;
    localparam int LOW_LSB     = 2;
    localparam int EID_LSB     = LOW_LSB + SCORE_BITS;
    localparam int ESC_LSB     = EID_LSB + ID_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;
    localparam int SETTLE_WAIT = 8;
    localparam int PHASE_ITEMS = 22;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_READOUT = 1'b1;

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [SCORE_BITS-1:0] score_t;

    typedef struct packed {
        logic   accepted;
        logic   full_res;
        score_t lowest_score;
        id_t    entry_id;
        score_t entry_score;
        logic   entry_valid;
        logic   last;
    } result_t;

    typedef enum logic [1:0] {ROW_INSERT, ROW_READOUT, ROW_CAPACITY} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        id_t              id;
        score_t           score;
        logic [CAP_W-1:0] cap;
        bit               typed;
        result_t          res;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata;   // record_id, score
    logic             s_tuser;   // command
    logic             m_tvalid;
    logic             m_tready;
    logic [M_W-1:0]   m_tdata;   // accepted, full_res, lowest_score, entry_id, entry_score
    logic             m_tuser;   // entry_valid
    logic             m_tlast;

    // local copy of the sorted score store
    id_t              store_ids [MAX_ENTRIES];
    score_t           store_scores [MAX_ENTRIES];
    int               store_count;
    logic [CAP_W-1:0] capacity_reg;

    result_t awaited_results [$];
    row_t    directed_rows [$];
    int      mismatches;
    int      cycles;
    int      src_idle_pct;
    int      snk_idle_pct;

    top_k_select_with_dedup_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS),
        .SCORE_BITS  (SCORE_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int cap_limit();
        int c;
        c = int'(capacity_reg);
        if (c < 1)
            c = 1;
        if (c > MAX_ENTRIES)
            c = MAX_ENTRIES;
        return c;
    endfunction

    function automatic void drop_bottom();
        if (store_count == 0)
            return;
        for (int i = 1; i < store_count; i++)
        begin
            store_ids[i-1]    = store_ids[i];
            store_scores[i-1] = store_scores[i];
        end
        store_count--;
    endfunction

    function automatic result_t store_result(logic acc, id_t eid, score_t esc,
                                             logic ev, logic lst);
        result_t r;
        r.accepted     = acc;
        r.full_res     = (store_count >= cap_limit());
        r.lowest_score = (store_count > 0) ? store_scores[0] : '0;
        r.entry_id     = eid;
        r.entry_score  = esc;
        r.entry_valid  = ev;
        r.last         = lst;
        return r;
    endfunction

    function automatic void queue_result(result_t r);
        awaited_results = {awaited_results, r};
    endfunction

    // apply one command to the local store and queue the results it causes
    function automatic void store_step(logic cmd, id_t id, score_t sc);
        bit dup;
        bit acc;
        int pos;
        dup = 0;
        if (cmd == CMD_INSERT)
        begin
            for (int i = 0; i < store_count; i++)
                if (store_ids[i] == id)
                    dup = 1;
            acc = !dup && (store_count < cap_limit() ||
                           (store_count > 0 && sc > store_scores[0]));
            if (acc)
            begin
                if (store_count >= cap_limit())
                    drop_bottom();
                pos = store_count;
                for (int i = 0; i < store_count; i++)
                begin
                    if (store_scores[i] > sc)
                    begin
                        pos = i;
                        break;
                    end
                end
                for (int i = store_count; i > pos; i--)
                begin
                    store_ids[i]    = store_ids[i-1];
                    store_scores[i] = store_scores[i-1];
                end
                store_ids[pos]    = id;
                store_scores[pos] = sc;
                store_count++;
            end
            queue_result(store_result(acc, '0, '0, 1'b0, 1'b1));
        end
        else if (store_count == 0)
            queue_result(store_result(1'b0, '0, '0, 1'b0, 1'b1));
        else
        begin
            for (int i = 0; i < store_count; i++)
                queue_result(store_result(1'b0, store_ids[i], store_scores[i],
                                          1'b1, (i + 1 == store_count)));
        end
    endfunction

    function automatic void add_row(row_kind_t kind, id_t id, score_t sc,
                                    logic [CAP_W-1:0] cap, bit typed, logic acc,
                                    logic full, score_t low);
        row_t r;
        r.kind  = kind;
        r.id    = id;
        r.score = sc;
        r.cap   = cap;
        r.typed = typed;
        r.res   = '{acc, full, low, '0, '0, 1'b0, 1'b1};
        directed_rows = {directed_rows, r};
    endfunction

    task automatic wait_drained();
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(logic cmd, id_t id, score_t sc, bit typed, result_t res);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_W'({sc, id});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        store_step(cmd, id, sc);
        // rows with a hand-written result replace the store's prediction
        if (typed)
            awaited_results[awaited_results.size()-1] = res;
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        capacity_reg = value;
        // lowered capacity drops the lowest entries at once
        while (store_count > cap_limit())
            drop_bottom();
    endtask

    function automatic id_t pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return id_t'($urandom_range(0, 23));
        if (r < 70)
            return $urandom_range(0, 1) ? '1 : '0;
        return id_t'($urandom());
    endfunction

    function automatic score_t pick_score();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return score_t'($urandom_range(0, 7)) << 16;
        if (r < 45)
            return $urandom_range(0, 1) ? '1 : '0;
        return score_t'($urandom());
    endfunction

    // receiver side: random backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.accepted     = m_tdata[0];
            got.full_res     = m_tdata[1];
            got.lowest_score = m_tdata[LOW_LSB +: SCORE_BITS];
            got.entry_id     = m_tdata[EID_LSB +: ID_BITS];
            got.entry_score  = m_tdata[ESC_LSB +: SCORE_BITS];
            got.entry_valid  = m_tuser;
            got.last         = m_tlast;
            if (awaited_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected transaction: acc=%0b full=%0b low=%h id=%h %s",
                             got.accepted, got.full_res, got.lowest_score, got.entry_id,
                             $sformatf("sc=%h v=%0b last=%0b", got.entry_score,
                                       got.entry_valid, got.last));
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.accepted !== want.accepted || got.full_res !== want.full_res ||
                    got.lowest_score !== want.lowest_score || got.entry_id !== want.entry_id ||
                    got.entry_score !== want.entry_score ||
                    got.entry_valid !== want.entry_valid || got.last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("expected acc=%0b full=%0b low=%h id=%h sc=%h v=%0b last=%0b",
                                 want.accepted, want.full_res, want.lowest_score,
                                 want.entry_id, want.entry_score, want.entry_valid, want.last);
                        $display("     got acc=%0b full=%0b low=%h id=%h sc=%h v=%0b last=%0b",
                                 got.accepted, got.full_res, got.lowest_score,
                                 got.entry_id, got.entry_score, got.entry_valid, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("top_k_select_with_dedup_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [CAP_W-1:0] phase_caps [6];
        row_t             row;
        logic             cmd;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_INSERT;
        store_count  = 0;
        capacity_reg = tkd_pkg::CAP_RESET;
        src_idle_pct = 30;
        snk_idle_pct = 46;

        add_row(ROW_READOUT,  '0,         '0,            '0,    1'b1, 1'b0, 1'b0, '0);
        add_row(ROW_INSERT,   '0,         '0,            '0,    1'b1, 1'b1, 1'b0, '0);
        add_row(ROW_INSERT,   '1,         '1,            '0,    1'b1, 1'b1, 1'b0, '0);
        // duplicate id is ignored
        add_row(ROW_INSERT,   '0,         32'd5,         '0,    1'b1, 1'b0, 1'b0, '0);
        add_row(ROW_INSERT,   24'h123456, 32'h8000_0000, '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_INSERT,   24'd2,      32'h8000_0000, '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_READOUT,  '0,         '0,            '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_CAPACITY, '0,         '0,            5'd2,  1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_READOUT,  '0,         '0,            '0,    1'b0, 1'b0, 1'b0, '0);
        // equal to the lowest score on a full store: rejected
        add_row(ROW_INSERT,   24'd3,      32'h8000_0000, '0,    1'b1, 1'b0, 1'b1,
                32'h8000_0000);
        add_row(ROW_INSERT,   24'd4,      32'h8000_0001, '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_READOUT,  '0,         '0,            '0,    1'b0, 1'b0, 1'b0, '0);
        // zero capacity acts as one
        add_row(ROW_CAPACITY, '0,         '0,            5'd0,  1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_INSERT,   24'd5,      32'd1,         '0,    1'b1, 1'b0, 1'b1, '1);
        add_row(ROW_INSERT,   24'd6,      '1,            '0,    1'b1, 1'b0, 1'b1, '1);
        add_row(ROW_INSERT,   '1,         '0,            '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_READOUT,  '0,         '0,            '0,    1'b0, 1'b0, 1'b0, '0);
        // above the store depth acts as the depth
        add_row(ROW_CAPACITY, '0,         '0,            5'd31, 1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_INSERT,   24'd7,      '0,            '0,    1'b1, 1'b1, 1'b0, '0);
        add_row(ROW_INSERT,   24'd8,      '0,            '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_READOUT,  '0,         '0,            '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_CAPACITY, '0,         '0,            5'd17, 1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_INSERT,   24'd9,      32'h0001_0000, '0,    1'b0, 1'b0, 1'b0, '0);
        add_row(ROW_READOUT,  '0,         '0,            '0,    1'b0, 1'b0, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            case (row.kind)
                ROW_CAPACITY: write_capacity(row.cap);
                ROW_INSERT:   send_item(CMD_INSERT, row.id, row.score, row.typed, row.res);
                default:      send_item(CMD_READOUT, row.id, row.score, row.typed, row.res);
            endcase
        end

        phase_caps[0] = 5'd5;
        phase_caps[1] = 5'd1;
        phase_caps[2] = 5'd16;
        phase_caps[3] = CAP_W'($urandom_range(2, 15));
        phase_caps[4] = 5'd17;
        phase_caps[5] = 5'd3;
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                src_idle_pct = 30;
                snk_idle_pct = 46;
            end
            else if (p < 4)
            begin
                src_idle_pct = 46;
                snk_idle_pct = 30;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_capacity(phase_caps[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == 12)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                cmd = ($urandom_range(0, 99) < 12) ? CMD_READOUT : CMD_INSERT;
                send_item(cmd, pick_id(), pick_score(), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("top_k_select_with_dedup_unit: match");
        else
            $display("top_k_select_with_dedup_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
src/tkd_pkg.sv
src/tkd_cell.sv
src/tkd_chain.sv
src/top_k_select_with_dedup_unit.sv
dv/tb_top_k_select_with_dedup_unit.sv
